// ===== rtl/obstacle_avoid_scan_turn_fsm_core_defines.svh =====
// ----------------------------------------------------------------------------
// Obstacle avoidance controller - assertion macros
// Shared concurrent assertion forms, sampled on clock and masked by reset.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_AVOID_SCAN_TURN_FSM_CORE_DEFINES_SVH
`define OBSTACLE_AVOID_SCAN_TURN_FSM_CORE_DEFINES_SVH

// same-cycle implication
`define OAST_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("oast assertion failed");

// next-cycle implication
`define OAST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("oast assertion failed");

`endif

// ===== rtl/oast_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoidance controller - package
// Mode, motor and servo codes, register map and shared word types.
// ----------------------------------------------------------------------------
package oast_pkg;

   localparam int TIME_WIDTH_DEF = 32;
   localparam int DIST_WIDTH_DEF = 16;

   localparam int MODE_W  = 3;
   localparam int MOTOR_W = 3;
   localparam int SERVO_W = 2;
   localparam int THR_W   = 15;
   localparam int DUR_W   = 16;

   localparam logic [MODE_W-1:0] MODE_FWD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BACK   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SCANL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SCANR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DECIDE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_TURNL  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_TURNR  = 3'd6;

   localparam logic [MOTOR_W-1:0] MOT_NONE  = 3'd0;
   localparam logic [MOTOR_W-1:0] MOT_STOP  = 3'd1;
   localparam logic [MOTOR_W-1:0] MOT_FWD   = 3'd2;
   localparam logic [MOTOR_W-1:0] MOT_BACK  = 3'd3;
   localparam logic [MOTOR_W-1:0] MOT_LEFT  = 3'd4;
   localparam logic [MOTOR_W-1:0] MOT_RIGHT = 3'd5;

   localparam logic [SERVO_W-1:0] SRV_NONE   = 2'd0;
   localparam logic [SERVO_W-1:0] SRV_CENTER = 2'd1;
   localparam logic [SERVO_W-1:0] SRV_LEFT   = 2'd2;
   localparam logic [SERVO_W-1:0] SRV_RIGHT  = 2'd3;

   localparam logic DIR_LEFT  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYST   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKUP = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUARTER = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF   = 3'd5;

   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [THR_W-1:0] safe_distance;
      logic [THR_W-1:0] hysteresis_margin;
      logic [DUR_W-1:0] backup_time;
      logic [DUR_W-1:0] settle_time;
      logic [DUR_W-1:0] quarter_turn_time;
      logic [DUR_W-1:0] half_turn_time;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      safe_distance:     15'd320,
      hysteresis_margin: 15'd80,
      backup_time:       16'd500,
      settle_time:       16'd300,
      quarter_turn_time: 16'd500,
      half_turn_time:    16'd1000
   };

   // motor_cmd sits in the lowest bits
   typedef struct packed {
      logic               last_direction;
      logic [MODE_W-1:0]  mode_now;
      logic [SERVO_W-1:0] servo_cmd;
      logic [MOTOR_W-1:0] motor_cmd;
   } rsp_type;

endpackage

// ===== rtl/oast_step.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoidance controller - step logic
// Next mode, timers, scan ranges and motor/servo commands for one update.
// ----------------------------------------------------------------------------
module oast_step #(
   parameter int TIME_WIDTH = oast_pkg::TIME_WIDTH_DEF,
   parameter int DIST_WIDTH = oast_pkg::DIST_WIDTH_DEF
) (
   input  logic [oast_pkg::MODE_W-1:0] mode,
   input  logic                        last_turn,
   input  logic [TIME_WIDTH-1:0]       timer_start,
   input  logic [oast_pkg::DUR_W-1:0]  turn_time,
   input  logic [DIST_WIDTH-2:0]       left_range,
   input  logic [DIST_WIDTH-2:0]       right_range,
   input  oast_pkg::cfg_type           cfg,
   input  logic [TIME_WIDTH-1:0]       now_ms,
   input  logic [DIST_WIDTH-1:0]       raw_distance,
   input  logic [DIST_WIDTH-1:0]       filtered_distance,
   output logic [oast_pkg::MODE_W-1:0] mode_in,
   output logic                        last_turn_in,
   output logic [TIME_WIDTH-1:0]       timer_start_in,
   output logic [oast_pkg::DUR_W-1:0]  turn_time_in,
   output logic [DIST_WIDTH-2:0]       left_range_in,
   output logic [DIST_WIDTH-2:0]       right_range_in,
   output oast_pkg::rsp_type           rsp
);
   import oast_pkg::*;

   localparam int RNG_W = DIST_WIDTH - 1;
   localparam int CMP_W = ((RNG_W > THR_W) ? RNG_W : THR_W) + 1;

   logic [TIME_WIDTH-1:0] elapsed;
   logic                  back_done;
   logic                  settle_done;
   logic                  turn_done;
   logic [RNG_W-1:0]      filt_clamp;
   logic [CMP_W-1:0]      left_x;
   logic [CMP_W-1:0]      right_x;
   logic [CMP_W-1:0]      safe_x;
   logic [CMP_W-1:0]      hyst_x;
   logic [CMP_W-1:0]      raw_x;
   logic                  raw_block;
   logic                  left_blk;
   logic                  right_blk;
   logic                  left_wide;
   logic                  right_wide;
   logic                  dir;
   logic [DUR_W-1:0]      dur;
   logic [MOTOR_W-1:0]    motor;
   logic [SERVO_W-1:0]    servo;

   assign elapsed     = now_ms - timer_start;
   assign back_done   = elapsed >= TIME_WIDTH'(cfg.backup_time);
   assign settle_done = elapsed >= TIME_WIDTH'(cfg.settle_time);
   assign turn_done   = elapsed >= TIME_WIDTH'(turn_time);

   // invalid scan reading counts as zero range
   assign filt_clamp = filtered_distance[DIST_WIDTH-1] ? '0 : filtered_distance[RNG_W-1:0];

   assign left_x  = CMP_W'(left_range);
   assign right_x = CMP_W'(right_range);
   assign safe_x  = CMP_W'(cfg.safe_distance);
   assign hyst_x  = CMP_W'(cfg.hysteresis_margin);
   assign raw_x   = CMP_W'(raw_distance[RNG_W-1:0]);

   assign raw_block  = raw_distance[DIST_WIDTH-1] || (raw_x <= safe_x);
   assign left_blk   = left_x < safe_x;
   assign right_blk  = right_x < safe_x;
   assign left_wide  = {1'b0, left_x} > ({1'b0, right_x} + {1'b0, hyst_x});
   assign right_wide = {1'b0, right_x} > ({1'b0, left_x} + {1'b0, hyst_x});

   always_comb begin
      dur = cfg.quarter_turn_time;
      if (left_blk && right_blk) begin
         dir = ~last_turn;
         dur = cfg.half_turn_time;
      end else if (left_blk) begin
         dir = DIR_RIGHT;
      end else if (right_blk) begin
         dir = DIR_LEFT;
      end else if (left_wide) begin
         dir = DIR_LEFT;
      end else if (right_wide) begin
         dir = DIR_RIGHT;
      end else begin
         dir = ~last_turn;
      end
   end

   always_comb begin
      mode_in        = mode;
      last_turn_in   = last_turn;
      timer_start_in = timer_start;
      turn_time_in   = turn_time;
      left_range_in  = left_range;
      right_range_in = right_range;
      motor          = MOT_NONE;
      servo          = SRV_NONE;
      case (mode)
         MODE_BACK: begin
            motor = MOT_BACK;
            if (back_done) begin
               motor          = MOT_STOP;
               servo          = SRV_LEFT;
               timer_start_in = now_ms;
               mode_in        = MODE_SCANL;
            end
         end
         MODE_SCANL: begin
            if (settle_done) begin
               left_range_in  = filt_clamp;
               servo          = SRV_RIGHT;
               timer_start_in = now_ms;
               mode_in        = MODE_SCANR;
            end
         end
         MODE_SCANR: begin
            if (settle_done) begin
               right_range_in = filt_clamp;
               servo          = SRV_CENTER;
               mode_in        = MODE_DECIDE;
            end
         end
         MODE_DECIDE: begin
            last_turn_in   = dir;
            turn_time_in   = dur;
            timer_start_in = now_ms;
            mode_in        = (dir == DIR_RIGHT) ? MODE_TURNR : MODE_TURNL;
         end
         MODE_TURNL, MODE_TURNR: begin
            motor = (mode == MODE_TURNL) ? MOT_LEFT : MOT_RIGHT;
            if (turn_done) begin
               motor   = MOT_STOP;
               mode_in = MODE_FWD;
            end
         end
         default: begin
            servo   = SRV_CENTER;
            motor   = MOT_FWD;
            mode_in = MODE_FWD;
            if (raw_block) begin
               motor          = MOT_STOP;
               timer_start_in = now_ms;
               mode_in        = MODE_BACK;
            end
         end
      endcase
   end

   assign rsp.motor_cmd      = motor;
   assign rsp.servo_cmd      = servo;
   assign rsp.mode_now       = mode_in;
   assign rsp.last_direction = last_turn_in;

endmodule

// ===== rtl/obstacle_avoid_scan_turn_fsm_core.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoidance controller - top level
// Drive, back off, scan both sides and turn; one command word per update.
//
//   channel | dir | handshake          | content
//   req     | in  | req_tvalid/tready  | now_ms, raw_distance, filtered_distance
//   rsp     | out | rsp_tvalid/tready  | motor_cmd, servo_cmd, mode_now, last_direction
//   csr     | in  | csr_valid/ready    | csr_index, csr_data
//
// One word per cycle while rsp is not stalled; rsp_tvalid rises once the word
// has passed the input register and the step logic into the result register.
// Mode and timer state advance when a word moves into the result register.
// A stalled rsp holds the result and, with the input register full, stalls req.
// csr_ready is always high. Synchronous reset restores defaults, no sweep.
// ----------------------------------------------------------------------------
module obstacle_avoid_scan_turn_fsm_core #(
   parameter  int TIME_WIDTH = oast_pkg::TIME_WIDTH_DEF,
   parameter  int DIST_WIDTH = oast_pkg::DIST_WIDTH_DEF,
   localparam int REQ_DATA_W = ((TIME_WIDTH + 2 * DIST_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_ms, raw_distance, filtered_distance, zero pad
   input  logic [REQ_DATA_W-1:0]            req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // motor_cmd, servo_cmd, mode_now, last_direction, zero pad
   output logic [oast_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [oast_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [oast_pkg::CSR_DATA_W-1:0]  csr_data
);
   import oast_pkg::*;

`include "obstacle_avoid_scan_turn_fsm_core_defines.svh"

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [TIME_WIDTH-1:0] in_now_ff;
   logic [DIST_WIDTH-1:0] in_raw_ff;
   logic [DIST_WIDTH-1:0] in_filt_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_type               out_ff;
   rsp_type               out_in;

   logic [MODE_W-1:0]     mode_ff;
   logic [MODE_W-1:0]     mode_in;
   logic                  last_turn_ff;
   logic                  last_turn_in;
   logic [TIME_WIDTH-1:0] timer_start_ff;
   logic [TIME_WIDTH-1:0] timer_start_in;
   logic [DUR_W-1:0]      turn_time_ff;
   logic [DUR_W-1:0]      turn_time_in;
   logic [DIST_WIDTH-2:0] left_range_ff;
   logic [DIST_WIDTH-2:0] left_range_in;
   logic [DIST_WIDTH-2:0] right_range_ff;
   logic [DIST_WIDTH-2:0] right_range_in;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;

   logic                  req_take;
   logic                  advance;
   logic                  commit;

   assign advance    = !out_valid_ff || rsp_tready;
   assign commit     = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !commit);
   assign out_valid_in = commit || (out_valid_ff && !rsp_tready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAFE:    cfg_in.safe_distance     = csr_data[THR_W-1:0];
            CSR_HYST:    cfg_in.hysteresis_margin = csr_data[THR_W-1:0];
            CSR_BACKUP:  cfg_in.backup_time       = csr_data[DUR_W-1:0];
            CSR_SETTLE:  cfg_in.settle_time       = csr_data[DUR_W-1:0];
            CSR_QUARTER: cfg_in.quarter_turn_time = csr_data[DUR_W-1:0];
            CSR_HALF:    cfg_in.half_turn_time    = csr_data[DUR_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   oast_step #(
      .TIME_WIDTH (TIME_WIDTH),
      .DIST_WIDTH (DIST_WIDTH)
   ) u_step (
      .mode              (mode_ff),
      .last_turn         (last_turn_ff),
      .timer_start       (timer_start_ff),
      .turn_time         (turn_time_ff),
      .left_range        (left_range_ff),
      .right_range       (right_range_ff),
      .cfg               (cfg_ff),
      .now_ms            (in_now_ff),
      .raw_distance      (in_raw_ff),
      .filtered_distance (in_filt_ff),
      .mode_in           (mode_in),
      .last_turn_in      (last_turn_in),
      .timer_start_in    (timer_start_in),
      .turn_time_in      (turn_time_in),
      .left_range_in     (left_range_in),
      .right_range_in    (right_range_in),
      .rsp               (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         cfg_ff         <= CFG_RESET;
         mode_ff        <= MODE_FWD;
         last_turn_ff   <= DIR_RIGHT;
         timer_start_ff <= '0;
         turn_time_ff   <= '0;
         left_range_ff  <= '0;
         right_range_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (commit) begin
            mode_ff        <= mode_in;
            last_turn_ff   <= last_turn_in;
            timer_start_ff <= timer_start_in;
            turn_time_ff   <= turn_time_in;
            left_range_ff  <= left_range_in;
            right_range_ff <= right_range_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff  <= req_tdata[TIME_WIDTH-1:0];
         in_raw_ff  <= req_tdata[TIME_WIDTH +: DIST_WIDTH];
         in_filt_ff <= req_tdata[TIME_WIDTH + DIST_WIDTH +: DIST_WIDTH];
      end
      if (commit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_ff);

   `OAST_ASSERT_IMPL(a_rsp_matches_state, out_valid_ff, (out_ff.mode_now == mode_ff) && (out_ff.last_direction == last_turn_ff))
   `OAST_ASSERT_IMPL(a_turn_dir_agrees, out_valid_ff && (out_ff.mode_now == MODE_TURNL || out_ff.mode_now == MODE_TURNR), out_ff.last_direction == (out_ff.mode_now == MODE_TURNR))
   `OAST_ASSERT_IMPL(a_obstacle_centres, out_valid_ff && out_ff.mode_now == MODE_BACK && out_ff.motor_cmd == MOT_STOP, out_ff.servo_cmd == SRV_CENTER)
   `OAST_ASSERT_NEXT(a_dir_only_on_turn, commit, (last_turn_ff == $past(last_turn_ff)) || mode_ff == MODE_TURNL || mode_ff == MODE_TURNR)

endmodule

// ===== dv/obstacle_avoid_scan_turn_fsm_core_checker.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoidance controller - checker
// Watches the req, rsp and csr channels of the controller. Each accepted
// update word is run through an independent model of the seven-mode drive /
// back-off / scan / turn machine. The predicted command word is queued and
// compared field by field with the next accepted rsp word.
// ----------------------------------------------------------------------------
module obstacle_avoid_scan_turn_fsm_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // now_ms, raw_distance, filtered_distance
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // motor_cmd, servo_cmd, mode_now, last_direction, zero pad
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          errors,
   output int          results_seen,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import oast_pkg::*;

   // controller state
   logic [2:0]  mode_q;
   logic        last_turn_q;
   logic [31:0] timer_q;
   logic [15:0] turn_len_q;
   int          left_cm;
   int          right_cm;

   // register copies
   int          safe_thr;
   int          hyst_thr;
   logic [15:0] backup_len;
   logic [15:0] settle_len;
   logic [15:0] quarter_len;
   logic [15:0] half_len;

   rsp_type     cmd_expected_q[$];

   function automatic rsp_type step_controller(input logic [31:0] now,
                                               input logic signed [15:0] raw,
                                               input logic signed [15:0] filt);
      rsp_type     r;
      logic [31:0] since;
      logic        lb;
      logic        rb;
      logic        dir;
      logic [15:0] dur;
      since       = now - timer_q;
      r.motor_cmd = MOT_NONE;
      r.servo_cmd = SRV_NONE;
      case (mode_q)
         MODE_BACK: begin
            r.motor_cmd = MOT_BACK;
            if (since >= {16'd0, backup_len}) begin
               r.motor_cmd = MOT_STOP;
               r.servo_cmd = SRV_LEFT;
               timer_q     = now;
               mode_q      = MODE_SCANL;
            end
         end
         MODE_SCANL: begin
            if (since >= {16'd0, settle_len}) begin
               left_cm     = (filt < 0) ? 0 : int'(filt);
               r.servo_cmd = SRV_RIGHT;
               timer_q     = now;
               mode_q      = MODE_SCANR;
            end
         end
         MODE_SCANR: begin
            if (since >= {16'd0, settle_len}) begin
               right_cm    = (filt < 0) ? 0 : int'(filt);
               r.servo_cmd = SRV_CENTER;
               mode_q      = MODE_DECIDE;
            end
         end
         MODE_DECIDE: begin
            lb  = left_cm < safe_thr;
            rb  = right_cm < safe_thr;
            dur = quarter_len;
            if (lb && rb) begin
               dir = ~last_turn_q;
               dur = half_len;
            end else if (lb) begin
               dir = DIR_RIGHT;
            end else if (rb) begin
               dir = DIR_LEFT;
            end else if (left_cm > right_cm + hyst_thr) begin
               dir = DIR_LEFT;
            end else if (right_cm > left_cm + hyst_thr) begin
               dir = DIR_RIGHT;
            end else begin
               dir = ~last_turn_q;
            end
            last_turn_q = dir;
            turn_len_q  = dur;
            timer_q     = now;
            mode_q      = (dir == DIR_RIGHT) ? MODE_TURNR : MODE_TURNL;
         end
         MODE_TURNL, MODE_TURNR: begin
            r.motor_cmd = (mode_q == MODE_TURNL) ? MOT_LEFT : MOT_RIGHT;
            if (since >= {16'd0, turn_len_q}) begin
               r.motor_cmd = MOT_STOP;
               mode_q      = MODE_FWD;
            end
         end
         default: begin
            r.servo_cmd = SRV_CENTER;
            r.motor_cmd = MOT_FWD;
            mode_q      = MODE_FWD;
            if (int'(raw) < 0 || int'(raw) <= safe_thr) begin
               r.motor_cmd = MOT_STOP;
               timer_q     = now;
               mode_q      = MODE_BACK;
            end
         end
      endcase
      r.mode_now       = mode_q;
      r.last_direction = last_turn_q;
      return r;
   endfunction

   task automatic report_field(input string fname, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t mismatch %s: expected %0d, actual %0d", $time, fname, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         mode_q       = MODE_FWD;
         last_turn_q  = DIR_RIGHT;
         timer_q      = '0;
         turn_len_q   = '0;
         left_cm      = 0;
         right_cm     = 0;
         safe_thr     = 320;
         hyst_thr     = 80;
         backup_len   = 16'd500;
         settle_len   = 16'd300;
         quarter_len  = 16'd500;
         half_len     = 16'd1000;
         errors       = 0;
         results_seen = 0;
         cmd_expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            results_seen++;
            if (cmd_expected_q.size() == 0) begin
               $display("%0t unexpected command word: expected none, actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = cmd_expected_q.pop_front();
               report_field("motor_cmd", want.motor_cmd, got.motor_cmd);
               report_field("servo_cmd", want.servo_cmd, got.servo_cmd);
               report_field("mode_now", want.mode_now, got.mode_now);
               report_field("last_direction", want.last_direction, got.last_direction);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAFE:    safe_thr    = int'(csr_data[14:0]);
               CSR_HYST:    hyst_thr    = int'(csr_data[14:0]);
               CSR_BACKUP:  backup_len  = csr_data;
               CSR_SETTLE:  settle_len  = csr_data;
               CSR_QUARTER: quarter_len = csr_data;
               CSR_HALF:    half_len    = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            cmd_expected_q.push_back(step_controller(req_tdata[31:0], req_tdata[47:32],
                                                     req_tdata[63:48]));
      end
      pending = cmd_expected_q.size();
   end

endmodule

// ===== dv/obstacle_avoid_scan_turn_fsm_core_tb.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoidance controller - testbench top
// Drives updates through a directed walk of every mode and three decisions,
// then phases of random, mostly time-ordered updates under several register
// settings (zeros, maxima, random). Both sides idle at random, the receiver
// holds off once for a long stretch; the checker predicts and compares.
// ----------------------------------------------------------------------------
module obstacle_avoid_scan_turn_fsm_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import oast_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 250;
   localparam int HOLD_CYCLES = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int          errors;
   int          results_seen;
   int          pending;
   int          items_sent;
   int          quiet_cycles;
   bit          steady;

   int          cur_safe;
   int          cur_hyst;
   int          cur_span;
   logic [31:0] clock_ms;

   obstacle_avoid_scan_turn_fsm_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   obstacle_avoid_scan_turn_fsm_core_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .errors       (errors),
      .results_seen (results_seen),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= 600) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 30);
         end
      end
   end

   task automatic send_update(input logic [31:0] now, input int raw, input int filt);
      while (!steady && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {filt[15:0], raw[15:0], now};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[15:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input int safe_v, input int hyst_v, input int backup_v,
                            input int settle_v, input int quarter_v, input int half_v);
      write_reg(CSR_SAFE, safe_v);
      write_reg(CSR_HYST, hyst_v);
      write_reg(CSR_BACKUP, backup_v);
      write_reg(CSR_SETTLE, settle_v);
      write_reg(CSR_QUARTER, quarter_v);
      write_reg(CSR_HALF, half_v);
      csr_valid <= 1'b0;
      @(posedge clock);
      cur_safe = safe_v;
      cur_hyst = hyst_v;
      cur_span = backup_v;
      if (settle_v > cur_span) cur_span = settle_v;
      if (quarter_v > cur_span) cur_span = quarter_v;
      if (half_v > cur_span) cur_span = half_v;
   endtask

   function automatic int pick_dist(input int center, input int spread);
      int v;
      case ($urandom_range(0, 9))
         0:       v = int'($urandom_range(0, 65535)) - 32768;
         1:       v = -int'($urandom_range(1, 32768));
         default: v = center - spread + int'($urandom_range(0, 2 * spread));
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic run_random(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            clock_ms = $urandom;
         else if (pick < 20)
            clock_ms = clock_ms + $urandom_range(0, 1);
         else
            clock_ms = clock_ms + $urandom_range(0, cur_span / 2 + 2);
         send_update(clock_ms, pick_dist(cur_safe, cur_hyst + 16),
                     pick_dist(cur_safe + cur_hyst, cur_hyst + 24));
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SAFE;
      csr_data   = '0;
      steady     = 1'b0;
      items_sent = 0;
      cur_safe   = 320;
      cur_hyst   = 80;
      cur_span   = 1000;
      clock_ms   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: walk every mode; left blocked, both blocked, left wider
      send_update(100, 32767, 0);
      send_update(110, 321, 0);
      send_update(120, 320, 0);        // at threshold
      send_update(300, 1000, 0);
      send_update(620, 1000, 0);
      send_update(700, 1000, 0);
      send_update(920, 1000, -32768);  // invalid scan clamps to zero
      send_update(1220, 1000, 32767);
      send_update(1230, 1000, 0);      // left blocked
      send_update(1500, 1000, 0);
      send_update(1730, 1000, 0);
      send_update(1740, -32768, 0);
      send_update(2240, 1000, 0);
      send_update(2540, 1000, 100);
      send_update(2840, 1000, 200);
      send_update(2850, 1000, 0);      // both blocked, half turn
      send_update(3850, 1000, 0);
      send_update(3860, -1, 0);
      send_update(4360, 1000, 0);
      send_update(4660, 1000, 2000);
      send_update(4960, 1000, 500);
      send_update(4970, 1000, 0);      // left wider
      send_update(5470, 1000, 0);
      drain();
      clock_ms = 32'd5470;

      for (int p = 0; p < 7; p++) begin
         case (p)
            1: configure(0, 0, 0, 0, 0, 0);
            3: configure(32767, 32767, 65535, 65535, 65535, 65535);
            4: configure($urandom_range(0, 32767), $urandom_range(0, 32767),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            default: configure($urandom_range(0, 1000), $urandom_range(0, 100),
                               $urandom_range(0, 50), $urandom_range(0, 50),
                               $urandom_range(0, 50), $urandom_range(0, 50));
         endcase
         steady = (p == 2);
         run_random(PHASE_ITEMS);
         drain();
      end

      if (errors == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
